// File: rtl/core/progression_reversed_decimal_unit_assert.svh
// Assertion macros for the progression reversed decimal unit
`ifndef PROGRESSION_REVERSED_DECIMAL_UNIT_ASSERT_SVH
`define PROGRESSION_REVERSED_DECIMAL_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every clock edge outside reset.
`define PRDU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("prdu assertion failed");
// Next-cycle implication.
`define PRDU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("prdu assertion failed");
`else
`define PRDU_ASSERT_NOW(label, ante, cons)
`define PRDU_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/core/prdu_pkg.sv
// Shared types and constants for the progression reversed decimal unit
package prdu_pkg;

  localparam int REG_W     = 32;
  localparam int REG_IDX_W = 1;
  localparam int CHAR_W    = 6;

  // Register indexes on the configuration port
  localparam logic [REG_IDX_W-1:0] REG_START_VALUE = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_STEP        = 1'b1;

  // ASCII codes, cut to the character width
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] ASCII_NINE  = 6'd57;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

  // Controller to datapath
  typedef struct packed {
    logic load;       // take a new term and start conversion
    logic conv;       // run one double-dabble step group
    logic shift;      // drop the digit just sent
    logic emit_sign;  // present the minus sign
  } prdu_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic digits_done;  // current digit is the most significant one
    logic negative;     // term being sent is negative
  } prdu_sts_t;

endpackage

// File: rtl/core/prdu_dp.sv
// Datapath: config registers, term accumulator, binary to BCD converter, char select
module prdu_dp import prdu_pkg::*; #(
  parameter int TERM_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_addr,
  input  logic [REG_W-1:0]     cfg_wdata,
  input  logic                 restart,
  input  prdu_cmd_t            cmd,
  output prdu_sts_t            sts,
  output logic [CHAR_W-1:0]    char_out
);

  localparam int CONV_STEPS = (TERM_WIDTH + 7) / 8;
  localparam int PAD_W      = CONV_STEPS * 8;
  localparam int NDIG       = (TERM_WIDTH * 77) / 256 + 1;
  localparam int BCD_W      = NDIG * 4;

  logic [REG_W-1:0]      start_r, start_nxt;
  logic [REG_W-1:0]      step_r, step_nxt;
  logic [TERM_WIDTH-1:0] term_r, term_nxt;
  logic                  started_r, started_nxt;
  logic                  neg_r, neg_nxt;
  logic [PAD_W-1:0]      bin_r, bin_nxt;
  logic [BCD_W-1:0]      bcd_r, bcd_nxt;

  logic [TERM_WIDTH-1:0] start_term;
  logic [TERM_WIDTH-1:0] step_term;
  logic [TERM_WIDTH-1:0] sel_term;
  logic [TERM_WIDTH-1:0] mag;
  logic [BCD_W-1:0]      dd_bcd;
  logic [PAD_W-1:0]      dd_bin;

  // Sign-extend the 32-bit registers, then cut to the term width
  logic [2*REG_W-1:0] start_ext, step_ext;
  assign start_ext  = {{REG_W{start_r[REG_W-1]}}, start_r};
  assign step_ext   = {{REG_W{step_r[REG_W-1]}}, step_r};
  assign start_term = start_ext[TERM_WIDTH-1:0];
  assign step_term  = step_ext[TERM_WIDTH-1:0];

  assign sel_term = (restart || !started_r) ? start_term : term_r;
  assign mag      = sel_term[TERM_WIDTH-1] ? (~sel_term + 1'b1) : sel_term;

  // Eight double-dabble steps per cycle
  always_comb begin
    dd_bcd = bcd_r;
    dd_bin = bin_r;
    for (int s = 0; s < 8; s++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (dd_bcd[d*4 +: 4] >= 4'd5) begin
          dd_bcd[d*4 +: 4] = dd_bcd[d*4 +: 4] + 4'd3;
        end
      end
      dd_bcd = {dd_bcd[BCD_W-2:0], dd_bin[PAD_W-1]};
      dd_bin = {dd_bin[PAD_W-2:0], 1'b0};
    end
  end

  always_comb begin
    start_nxt   = start_r;
    step_nxt    = step_r;
    term_nxt    = term_r;
    started_nxt = started_r;
    neg_nxt     = neg_r;
    bin_nxt     = bin_r;
    bcd_nxt     = bcd_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_START_VALUE: start_nxt = cfg_wdata;
        REG_STEP:        step_nxt  = cfg_wdata;
        default:         ;
      endcase
    end
    if (cmd.load) begin
      term_nxt    = sel_term + step_term;
      started_nxt = 1'b1;
      neg_nxt     = sel_term[TERM_WIDTH-1];
      bin_nxt     = PAD_W'(mag);
      bcd_nxt     = '0;
    end else if (cmd.conv) begin
      bin_nxt = dd_bin;
      bcd_nxt = dd_bcd;
    end else if (cmd.shift) begin
      bcd_nxt = bcd_r >> 4;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r   <= '0;
      step_r    <= '0;
      started_r <= 1'b0;
    end else begin
      start_r   <= start_nxt;
      step_r    <= step_nxt;
      started_r <= started_nxt;
    end
  end

  always_ff @(posedge clk) begin
    term_r <= term_nxt;
    neg_r  <= neg_nxt;
    bin_r  <= bin_nxt;
    bcd_r  <= bcd_nxt;
  end

  assign sts.digits_done = (bcd_r[BCD_W-1:4] == '0);
  assign sts.negative    = neg_r;
  assign char_out = cmd.emit_sign ? ASCII_MINUS : (ASCII_ZERO + CHAR_W'(bcd_r[3:0]));

endmodule

// File: rtl/core/prdu_ctrl.sv
// Controller: accepts a request, sequences conversion and character beats
module prdu_ctrl import prdu_pkg::*; #(
  parameter int TERM_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  output logic      out_tlast,
  input  prdu_sts_t sts,
  output prdu_cmd_t cmd
);

  localparam int CONV_STEPS = (TERM_WIDTH + 7) / 8;
  localparam int CNT_W      = (CONV_STEPS > 1) ? $clog2(CONV_STEPS) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_DIG  = 2'd2;
  localparam logic [1:0] S_SIGN = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             dig_last;

  assign dig_last = sts.digits_done && !sts.negative;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (in_tvalid) state_nxt = S_CONV;
      end
      S_CONV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(CONV_STEPS - 1)) state_nxt = S_DIG;
      end
      S_DIG: begin
        if (out_tready && sts.digits_done) begin
          state_nxt = sts.negative ? S_SIGN : S_IDLE;
        end
      end
      S_SIGN: begin
        if (out_tready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_DIG) || (state_r == S_SIGN);
  assign out_tlast  = (state_r == S_SIGN) || ((state_r == S_DIG) && dig_last);

  assign cmd.load      = (state_r == S_IDLE) && in_tvalid;
  assign cmd.conv      = (state_r == S_CONV);
  assign cmd.shift     = (state_r == S_DIG) && out_tready && !sts.digits_done;
  assign cmd.emit_sign = (state_r == S_SIGN);

endmodule

// File: rtl/core/progression_reversed_decimal_unit.sv
// Top level: arithmetic progression sent as reversed decimal text
// Usage:
//   Each beat on the in_ channel requests the next term of the progression;
//   in_tdata bit 0 (restart) reloads the term from start_value first. The
//   first beat after reset always restarts. The term goes out on the out_
//   channel one ASCII character per beat, least significant digit first,
//   then '-' for a negative term; out_tlast marks the final character.
//   Configuration: cfg_addr 0 = start_value, 1 = step, written with cfg_we.
// Sequencing:
//   After an accepted beat, the term is converted in the double-dabble unit
//   (8 bits per cycle), then sent one character per beat. One term is in
//   flight at a time; in_tready is high only when idle.
// Reset and stall:
//   Reset clears both registers and the run, so the next request starts a new
//   run at start_value. When out_tready is low the current character and
//   out_tlast hold until taken.
module progression_reversed_decimal_unit import prdu_pkg::*; #(
  parameter int TERM_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [0] restart, [7:1] zero
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // [5:0] character, [7:6] zero
  output logic                 out_tlast,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_addr,
  input  logic [REG_W-1:0]     cfg_wdata
);

  prdu_cmd_t         cmd;
  prdu_sts_t         sts;
  logic [CHAR_W-1:0] char_out;

  prdu_ctrl #(.TERM_WIDTH(TERM_WIDTH)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tlast  (out_tlast),
    .sts        (sts),
    .cmd        (cmd)
  );

  prdu_dp #(.TERM_WIDTH(TERM_WIDTH)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .restart   (in_tdata[0]),
    .cmd       (cmd),
    .sts       (sts),
    .char_out  (char_out)
  );

  assign out_tdata = {2'b00, char_out};

`include "progression_reversed_decimal_unit_assert.svh"

  `PRDU_ASSERT_NOW(a_one_term_at_a_time, out_tvalid, !in_tready)
  `PRDU_ASSERT_NOW(a_char_legal, out_tvalid, ((out_tdata[5:0] >= ASCII_ZERO) && (out_tdata[5:0] <= ASCII_NINE)) || (out_tdata[5:0] == ASCII_MINUS))
  `PRDU_ASSERT_NOW(a_minus_is_last, out_tvalid && (out_tdata[5:0] == ASCII_MINUS), out_tlast)
  `PRDU_ASSERT_NEXT(a_idle_after_last, out_tvalid && out_tready && out_tlast, in_tready)

endmodule
